FILE: src/value_coverage_map_update_defines.svh
// ---------------------------------------------------------------------------
// value coverage map update: assertion macros
// shared property forms used at the end of the top level
// ---------------------------------------------------------------------------
`ifndef VALUE_COVERAGE_MAP_UPDATE_DEFINES_SVH
`define VALUE_COVERAGE_MAP_UPDATE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define VCM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define VCM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/vcm_pkg.sv
// ---------------------------------------------------------------------------
// vcm_pkg
// types, constants and helper functions of the value coverage map update
// ---------------------------------------------------------------------------
package vcm_pkg;

	// map geometry
	localparam int MAP_ENTRIES = 65536;
	localparam int MAP_AW      = $clog2(MAP_ENTRIES);
	localparam int MAP_INDEX_W = 16;

	// values at or above this limit (signed) are dropped as pointer-like
	localparam logic [63:0] SKIP_LIMIT = 64'h0000_0000_0040_0000;
	localparam int          SKIP_BIT   = $clog2(SKIP_LIMIT);

	// mix hash
	localparam logic [63:0] MIX_MUL_A = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [63:0] MIX_MUL_B = 64'h94d0_49bb_1331_11eb;
	localparam int          MIX_SH_0  = 30;
	localparam int          MIX_SH_1  = 27;
	localparam int          MIX_SH_2  = 31;

	// configuration port
	localparam int          CFG_IDX_W        = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOSSY_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT_ENABLE = 2'd1;

	typedef enum logic [1:0] {
		CMD_RECORD       = 2'd0,
		CMD_AGGREGATE    = 2'd1,
		CMD_STORE        = 2'd2,
		CMD_STORE_SINGLE = 2'd3
	} cmd_t;

	// signed value >= SKIP_LIMIT
	function automatic logic pointer_like(input logic [63:0] v);
		return !v[63] && (v[62:SKIP_BIT] != '0);
	endfunction

	// eight-bit reduction of a value for lossy aggregation
	function automatic logic [7:0] lossy_code(input logic [63:0] v);
		logic [7:0]  res;
		logic [7:0]  t;
		logic [24:0] low;
		res = {v[63], 6'b0, v[0]};
		low = {3'b0, v[21:0]};
		for (int i = 0; i < 3; i++) begin
			t = low[1 + 8 * i +: 8];
			t = t ^ (t >> 1);
			t = t ^ (t >> 4);
			t = t & 8'h05;
			t = ((t >> 1) ^ t) & 8'h03;
			res[1 + 2 * i +: 2] = t[1:0];
		end
		return res;
	endfunction

	// location plus byte fold of the value, wrapped to the map
	function automatic logic [MAP_AW-1:0] record_index(input logic [15:0] loc,
		input logic [63:0] v);
		logic [15:0] sum;
		sum = loc + {8'h00, v[7:0] ^ v[15:8]};
		return sum[MAP_AW-1:0];
	endfunction

	// accumulator folded to 16 bits, xor block id, wrapped to the map
	function automatic logic [MAP_AW-1:0] store_index(input logic [15:0] loc,
		input logic [63:0] acc);
		logic [15:0] x;
		x = loc ^ acc[15:0] ^ acc[31:16] ^ acc[47:32] ^ acc[63:48];
		return x[MAP_AW-1:0];
	endfunction

endpackage

FILE: src/vcm_ram.sv
// ---------------------------------------------------------------------------
// vcm_ram
// generic simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module vcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/value_coverage_map_update.sv
// record: decode, read, write; store: index, read, write; aggregate: two mix rounds
// a skipped record or a skipped plain aggregate goes from decode straight to finish
// next item accepted in the cycle after a result is handed to the output register
// the 64-bit mix runs on one shared 32x32 multiplier
// map read-modify-write goes through one registered-read ram port
// after reset the map is cleared one entry per cycle, no item taken meanwhile
// ---------------------------------------------------------------------------
// value_coverage_map_update
// store-value coverage: byte map update, 64-bit hash aggregate, event counters
// ---------------------------------------------------------------------------
`include "value_coverage_map_update_defines.svh"

module value_coverage_map_update (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_we,
	input  logic [vcm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic                                 cfg_data,
	// input items
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           command,
	input  logic [15:0]                          location,
	input  logic [7:0]                           bitmask,
	input  logic signed [63:0]                   value,
	// result items
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 map_written,
	output logic [vcm_pkg::MAP_INDEX_W-1:0]      map_index,
	output logic [7:0]                           map_byte,
	output logic                                 was_skipped,
	output logic [31:0]                          total_events,
	output logic [31:0]                          skipped_events
);

	typedef enum logic [3:0] {
		ST_CLEAR,   // post-reset sweep of the map
		ST_IDLE,    // waiting for an item
		ST_DECODE,  // count, skip check, first mix step or map index
		ST_MUL,     // one 64x64 low-half multiply on the shared unit
		ST_MIX,     // xor-shift between multiplies, accumulator update
		ST_STIDX,   // fold accumulator into a store index, clear it
		ST_RD,      // map read
		ST_WR,      // map write of old byte ORed with bitmask
		ST_FIN      // hand result to the output register
	} state_t;

	state_t                      state_q;
	logic [vcm_pkg::MAP_AW-1:0]  clr_cnt_q;

	// configuration
	logic                        lossy_q;
	logic                        count_en_q;

	// captured item
	vcm_pkg::cmd_t               cmd_q;
	logic [15:0]                 loc_q;
	logic [7:0]                  mask_q;
	logic [63:0]                 val_q;

	// hash state
	logic [63:0]                 acc_q;
	logic [63:0]                 x_q;      // multiplicand of the current round
	logic [63:0]                 prod_q;   // low 64 bits of the product
	logic                        round_q;  // 0: first multiply, 1: second
	logic [1:0]                  mstep_q;

	// shared multiplier, product registered
	logic [31:0]                 mul_a;
	logic [31:0]                 mul_b;
	logic [63:0]                 mul_prod_s1;
	logic [63:0]                 mul_k;

	// counters
	logic [31:0]                 evt_cnt_q;
	logic [31:0]                 skip_cnt_q;

	// working result
	logic [vcm_pkg::MAP_AW-1:0]  idx_q;
	logic [7:0]                  byte_q;
	logic                        written_q;
	logic                        skipped_q;

	// output register
	logic                        out_valid_q;
	logic                        out_written_q;
	logic [vcm_pkg::MAP_AW-1:0]  out_idx_q;
	logic [7:0]                  out_byte_q;
	logic                        out_skipped_q;
	logic [31:0]                 out_evt_q;
	logic [31:0]                 out_skip_q;

	// map port
	logic                        ram_we;
	logic [vcm_pkg::MAP_AW-1:0]  ram_waddr;
	logic [7:0]                  ram_wdata;
	logic [7:0]                  ram_rdata;

	// decode-time helpers
	logic                        val_skip;
	logic [7:0]                  agg_loc;
	logic [63:0]                 pre_mix;
	logic                        out_free;
	logic                        out_load;

	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_FIN) && out_free;

	// aggregate uses the low location byte, store single uses location zero
	assign val_skip = vcm_pkg::pointer_like(val_q);
	assign agg_loc  = (cmd_q == vcm_pkg::CMD_AGGREGATE) ? loc_q[7:0] : 8'h00;

	always_comb begin
		if (lossy_q) begin
			pre_mix = {48'h0, agg_loc, 8'h00} ^ {56'h0, vcm_pkg::lossy_code(val_q)};
		end else begin
			pre_mix = {agg_loc, 56'h0} ^ val_q;
		end
	end

	// shared multiplier operand select
	// step 0: xL*kL (full), step 1: xH*kL, step 2: xL*kH (low halves, shifted up)
	assign mul_k = round_q ? vcm_pkg::MIX_MUL_B : vcm_pkg::MIX_MUL_A;
	assign mul_a = (mstep_q == 2'd1) ? x_q[63:32] : x_q[31:0];
	assign mul_b = (mstep_q == 2'd2) ? mul_k[63:32] : mul_k[31:0];

	always_ff @(posedge clk) begin
		mul_prod_s1 <= mul_a * mul_b;
	end

	// map storage
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata | mask_q;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = 8'h00;
		end else if (state_q == ST_WR) begin
			ram_we = 1'b1;
		end
	end

	vcm_ram #(
		.WIDTH (8),
		.DEPTH (vcm_pkg::MAP_ENTRIES)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_cnt_q     <= '0;
			lossy_q       <= 1'b0;
			count_en_q    <= 1'b0;
			cmd_q         <= vcm_pkg::CMD_RECORD;
			loc_q         <= '0;
			mask_q        <= '0;
			val_q         <= '0;
			acc_q         <= '0;
			x_q           <= '0;
			prod_q        <= '0;
			round_q       <= 1'b0;
			mstep_q       <= '0;
			evt_cnt_q     <= '0;
			skip_cnt_q    <= '0;
			idx_q         <= '0;
			byte_q        <= '0;
			written_q     <= 1'b0;
			skipped_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			out_written_q <= 1'b0;
			out_idx_q     <= '0;
			out_byte_q    <= '0;
			out_skipped_q <= 1'b0;
			out_evt_q     <= '0;
			out_skip_q    <= '0;
		end else begin
			// register writes, taken in any state
			if (cfg_we) begin
				unique case (cfg_index)
					vcm_pkg::CFG_LOSSY_MODE:   lossy_q    <= cfg_data;
					vcm_pkg::CFG_COUNT_ENABLE: count_en_q <= cfg_data;
					default: ;
				endcase
			end

			// new result loaded, or the held one taken downstream
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == '1) begin
						state_q <= ST_IDLE;
					end
				end

				ST_IDLE: begin
					if (in_valid) begin
						cmd_q   <= vcm_pkg::cmd_t'(command);
						loc_q   <= location;
						mask_q  <= bitmask;
						val_q   <= value;
						state_q <= ST_DECODE;
					end
				end

				ST_DECODE: begin
					written_q <= 1'b0;
					skipped_q <= 1'b0;
					idx_q     <= '0;
					byte_q    <= '0;
					round_q   <= 1'b0;
					mstep_q   <= '0;
					// every command but a plain store counts one event while counting is enabled, saturating
					if (cmd_q != vcm_pkg::CMD_STORE && count_en_q && evt_cnt_q != '1) begin
						evt_cnt_q <= evt_cnt_q + 32'd1;
					end
					if (cmd_q != vcm_pkg::CMD_STORE && val_skip && count_en_q &&
						skip_cnt_q != '1) begin
						skip_cnt_q <= skip_cnt_q + 32'd1;
					end
					unique case (cmd_q) inside
						vcm_pkg::CMD_RECORD: begin
							if (val_skip) begin
								skipped_q <= 1'b1;
								state_q   <= ST_FIN;
							end else begin
								idx_q   <= vcm_pkg::record_index(loc_q, val_q);
								state_q <= ST_RD;
							end
						end
						vcm_pkg::CMD_AGGREGATE, vcm_pkg::CMD_STORE_SINGLE: begin
							if (val_skip) begin
								// a skipped store single still stores
								skipped_q <= 1'b1;
								state_q   <= (cmd_q == vcm_pkg::CMD_AGGREGATE) ?
									ST_FIN : ST_STIDX;
							end else begin
								x_q     <= pre_mix ^ (pre_mix >> vcm_pkg::MIX_SH_0);
								state_q <= ST_MUL;
							end
						end
						vcm_pkg::CMD_STORE: begin
							state_q <= ST_STIDX;
						end
					endcase
				end

				ST_MUL: begin
					mstep_q <= mstep_q + 2'd1;
					if (mstep_q == 2'd1) begin
						prod_q <= mul_prod_s1;
					end else if (mstep_q != 2'd0) begin
						prod_q <= prod_q + {mul_prod_s1[31:0], 32'h0};
					end
					if (mstep_q == 2'd3) begin
						state_q <= ST_MIX;
					end
				end

				ST_MIX: begin
					mstep_q <= '0;
					if (!round_q) begin
						x_q     <= prod_q ^ (prod_q >> vcm_pkg::MIX_SH_1);
						round_q <= 1'b1;
						state_q <= ST_MUL;
					end else begin
						acc_q   <= acc_q ^ prod_q ^ (prod_q >> vcm_pkg::MIX_SH_2);
						state_q <= (cmd_q == vcm_pkg::CMD_STORE_SINGLE) ? ST_STIDX : ST_FIN;
					end
				end

				ST_STIDX: begin
					idx_q   <= vcm_pkg::store_index(loc_q, acc_q);
					acc_q   <= '0;
					state_q <= ST_RD;
				end

				ST_RD: begin
					state_q <= ST_WR;
				end

				ST_WR: begin
					byte_q    <= ram_wdata;
					written_q <= 1'b1;
					state_q   <= ST_FIN;
				end

				ST_FIN: begin
					if (out_load) begin
						out_written_q <= written_q;
						out_idx_q     <= idx_q;
						out_byte_q    <= byte_q;
						out_skipped_q <= skipped_q;
						out_evt_q     <= evt_cnt_q;
						out_skip_q    <= skip_cnt_q;
						state_q       <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign map_written    = out_written_q;
	assign map_index      = vcm_pkg::MAP_INDEX_W'(out_idx_q);
	assign map_byte       = out_byte_q;
	assign was_skipped    = out_skipped_q;
	assign total_events   = out_evt_q;
	assign skipped_events = out_skip_q;

	// checks
	`VCM_ASSERT_SAME(a_no_item_in_clear, state_q == ST_CLEAR, in_stall, "item taken during map clear")
	`VCM_ASSERT_NEXT(a_acc_cleared, state_q == ST_STIDX, acc_q == 64'h0, "accumulator not cleared by store")
	`VCM_ASSERT_NEXT(a_cnt_hold, !count_en_q, $stable(evt_cnt_q) && $stable(skip_cnt_q), "counter moved while disabled")

endmodule
